### rtl/core/pcsw_pkg.sv
package pcsw_pkg;

  localparam logic [1:0] KIND_SIG   = 2'd0;
  localparam logic [1:0] KIND_CHUNK = 2'd1;
  localparam logic [1:0] KIND_OVL   = 2'd2;

  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam int unsigned CHUNK_OVERHEAD = 12;
  localparam int unsigned SIG_LEN = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic        good;
    logic        endc;
  } rec_meta_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/pcsw_if.sv
interface pcsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface pcsw_out_if #(parameter int OFFSET_BITS = 48);
  logic                   valid;
  logic                   ready;
  logic [1:0]             record_kind;
  logic [OFFSET_BITS-1:0] record_offset;
  logic [OFFSET_BITS-1:0] record_size;
  logic [31:0]            chunk_tag;
  logic                   signature_good;
  logic                   end_chunk;

  modport source (output valid, record_kind, record_offset, record_size, chunk_tag,
                  signature_good, end_chunk, input ready);
  modport sink (input valid, record_kind, record_offset, record_size, chunk_tag,
                signature_good, end_chunk, output ready);
endinterface

### rtl/core/png_chunk_stream_walker_core.sv
// Channel   Dir  Beat
// in_ch     in   data_byte[7:0], final_byte
// out_ch    out  record_kind, record_offset, record_size, chunk_tag,
//                signature_good, end_chunk
// cfg       in   cfg_we, cfg_data[2:0] (parts_mask)
//
// One byte per cycle while the queue has room; a record passes through the queue and the output register.
// The front walker advances phase and offsets on every accepted byte; a two-entry queue and
// the output register let it run ahead of a stalled output by up to three records.
// Synchronous reset clears the walk, the queue and sets parts_mask to 7.
// in_ch.ready drops only while the queue is full.
module png_chunk_stream_walker_core #(
  parameter int OFFSET_BITS = 48
) (
  input  logic       clk,
  input  logic       rst,
  pcsw_in_if.sink    in_ch,
  pcsw_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data
);

  localparam int QW = $bits(pcsw_pkg::rec_meta_t) + 2 * OFFSET_BITS;

  logic                   ev_valid;
  logic                   ev_ready;
  pcsw_pkg::rec_meta_t    ev_meta;
  logic [OFFSET_BITS-1:0] ev_ofs;
  logic [OFFSET_BITS-1:0] ev_size;

  logic                   q_valid;
  logic                   q_pop;
  logic [QW-1:0]          q_data;
  pcsw_pkg::rec_meta_t    q_meta;
  logic [OFFSET_BITS-1:0] q_ofs;
  logic [OFFSET_BITS-1:0] q_size;

  pcsw_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev_meta  (ev_meta),
    .ev_ofs   (ev_ofs),
    .ev_size  (ev_size)
  );

  pcsw_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (ev_valid),
    .push_ready (ev_ready),
    .push_data  ({ev_meta, ev_ofs, ev_size}),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign {q_meta, q_ofs, q_size} = q_data;

  pcsw_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_meta   (q_meta),
    .q_ofs    (q_ofs),
    .q_size   (q_size),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

endmodule

### rtl/core/pcsw_front.sv
module pcsw_front #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  pcsw_in_if.sink                in_ch,
  output logic                   ev_valid,
  input  logic                   ev_ready,
  output pcsw_pkg::rec_meta_t    ev_meta,
  output logic [OFFSET_BITS-1:0] ev_ofs,
  output logic [OFFSET_BITS-1:0] ev_size
);

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] FIRST_CHUNK = OFFSET_BITS'(pcsw_pkg::SIG_LEN);

  typedef enum logic [2:0] {PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_DONE} phase_t;

  phase_t                 phase, phase_next;
  logic [31:0]            count, count_next, count_inc;
  logic [OFFSET_BITS-1:0] file_offset, file_offset_next, total;
  logic [OFFSET_BITS-1:0] chunk_start, chunk_start_next;
  logic [31:0]            chunk_length, chunk_length_next;
  logic [31:0]            chunk_type, chunk_type_next;
  logic                   sig_match, sig_match_next;
  logic [OFFSET_BITS:0]   chunk_size;
  logic                   acc;

  assign acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready = ev_ready;
  assign count_inc   = count + 32'd1;
  assign total       = (file_offset == OFS_MAX) ? file_offset : file_offset + 1'b1;
  assign chunk_size  = {1'b0, OFFSET_BITS'(chunk_length)}
                     + (OFFSET_BITS+1)'(pcsw_pkg::CHUNK_OVERHEAD);

  always_comb begin
    phase_next        = phase;
    count_next        = count;
    file_offset_next  = file_offset;
    chunk_start_next  = chunk_start;
    chunk_length_next = chunk_length;
    chunk_type_next   = chunk_type;
    sig_match_next    = sig_match;
    ev_valid          = 1'b0;
    ev_meta           = '0;
    ev_ofs            = '0;
    ev_size           = '0;
    if (acc) begin
      unique case (phase)
        PH_SIG: begin
          sig_match_next = sig_match &&
                           (in_ch.data_byte == pcsw_pkg::magic_byte(count[2:0]));
          if (count[2:0] == 3'd7) begin
            phase_next    = PH_LEN;
            count_next    = '0;
            ev_valid      = 1'b1;
            ev_meta.kind  = pcsw_pkg::KIND_SIG;
            ev_meta.good  = sig_match_next;
            ev_size       = FIRST_CHUNK;
          end else begin
            count_next = count_inc;
          end
        end
        PH_LEN: begin
          chunk_length_next = {chunk_length[23:0], in_ch.data_byte};
          if (count[1:0] == 2'd3) begin
            phase_next = PH_TYPE;
            count_next = '0;
          end else begin
            count_next = count_inc;
          end
        end
        PH_TYPE: begin
          chunk_type_next = {chunk_type[23:0], in_ch.data_byte};
          if (count[1:0] == 2'd3) begin
            phase_next = (chunk_length == '0) ? PH_CRC : PH_DATA;
            count_next = '0;
          end else begin
            count_next = count_inc;
          end
        end
        PH_DATA: begin
          if (count_inc == chunk_length) begin
            phase_next = PH_CRC;
            count_next = '0;
          end else begin
            count_next = count_inc;
          end
        end
        PH_CRC: begin
          if (count[1:0] == 2'd3) begin
            ev_valid          = 1'b1;
            ev_meta.kind      = pcsw_pkg::KIND_CHUNK;
            ev_meta.tag       = chunk_type;
            ev_meta.endc      = (chunk_type == pcsw_pkg::TAG_IEND);
            ev_ofs            = chunk_start;
            ev_size           = chunk_size[OFFSET_BITS-1:0];
            chunk_start_next  = total;
            count_next        = '0;
            chunk_length_next = '0;
            chunk_type_next   = '0;
            phase_next        = (chunk_type == pcsw_pkg::TAG_IEND) ? PH_DONE : PH_LEN;
          end else begin
            count_next = count_inc;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
      file_offset_next = total;

      if (in_ch.final_byte) begin
        if (phase_next == PH_SIG) begin
          // short file: signature fails
          ev_valid     = 1'b1;
          ev_meta      = '0;
          ev_meta.kind = pcsw_pkg::KIND_SIG;
          ev_ofs       = '0;
          ev_size      = FIRST_CHUNK;
        end else if (!ev_valid) begin
          // overlay candidate; back end drops it when empty
          ev_valid     = 1'b1;
          ev_meta      = '0;
          ev_meta.kind = pcsw_pkg::KIND_OVL;
          ev_ofs       = chunk_start_next;
          ev_size      = total;
        end
        phase_next        = PH_SIG;
        count_next        = '0;
        file_offset_next  = '0;
        chunk_start_next  = FIRST_CHUNK;
        chunk_length_next = '0;
        chunk_type_next   = '0;
        sig_match_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      count        <= '0;
      file_offset  <= '0;
      chunk_start  <= FIRST_CHUNK;
      chunk_length <= '0;
      chunk_type   <= '0;
      sig_match    <= 1'b1;
    end else begin
      phase        <= phase_next;
      count        <= count_next;
      file_offset  <= file_offset_next;
      chunk_start  <= chunk_start_next;
      chunk_length <= chunk_length_next;
      chunk_type   <= chunk_type_next;
      sig_match    <= sig_match_next;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && in_ch.final_byte) |=> (phase == PH_SIG && file_offset == '0 && sig_match))
    else $error("walk state not cleared after final beat");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk_length != '0))
    else $error("data phase entered with zero chunk length");

endmodule

### rtl/core/pcsw_queue.sv
module pcsw_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

### rtl/core/pcsw_back.sv
module pcsw_back #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  pcsw_pkg::rec_meta_t    q_meta,
  input  logic [OFFSET_BITS-1:0] q_ofs,
  input  logic [OFFSET_BITS-1:0] q_size,
  pcsw_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_data
);

  logic [2:0]             parts_mask;
  logic                   out_valid;
  logic [1:0]             kind;
  logic [OFFSET_BITS-1:0] offset;
  logic [OFFSET_BITS-1:0] size;
  logic [31:0]            tag;
  logic                   good;
  logic                   endc;
  logic                   emit;
  logic [OFFSET_BITS-1:0] ovl_size;

  assign q_pop    = q_valid && (!out_valid || out_ch.ready);
  assign ovl_size = q_size - q_ofs;

  always_comb begin
    unique case (q_meta.kind)
      pcsw_pkg::KIND_SIG:   emit = parts_mask[0];
      pcsw_pkg::KIND_CHUNK: emit = parts_mask[1];
      pcsw_pkg::KIND_OVL:   emit = parts_mask[2] && (q_ofs < q_size);
      default:              emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      parts_mask <= 3'b111;
    end else begin
      if (cfg_we) parts_mask <= cfg_data;
      if (q_pop) begin
        out_valid <= emit;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: load on pop, drop masked records by leaving valid low
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind   <= q_meta.kind;
      offset <= q_ofs;
      size   <= (q_meta.kind == pcsw_pkg::KIND_OVL) ? ovl_size : q_size;
      tag    <= q_meta.tag;
      good   <= q_meta.good;
      endc   <= q_meta.endc;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.record_kind    = kind;
  assign out_ch.record_offset  = offset;
  assign out_ch.record_size    = size;
  assign out_ch.chunk_tag      = tag;
  assign out_ch.signature_good = good;
  assign out_ch.end_chunk      = endc;

  a_ovl_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == pcsw_pkg::KIND_OVL) |-> (size != '0))
    else $error("empty overlay record emitted");

  a_sig_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == pcsw_pkg::KIND_SIG) |->
      (offset == '0 && size == OFFSET_BITS'(pcsw_pkg::SIG_LEN) && !endc && tag == '0))
    else $error("malformed signature record");

  a_nonchunk_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != pcsw_pkg::KIND_CHUNK) |-> (tag == '0 && !endc))
    else $error("chunk fields set on non-chunk record");

endmodule

### verif/tb_top.sv
module tb_top;

  localparam int OB = 48;
  localparam int unsigned PHASE_BYTES = 75;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;

  localparam logic [2:0] MASK_NONE  = 3'b000;
  localparam logic [2:0] MASK_SIG   = 3'b001;
  localparam logic [2:0] MASK_CHUNK = 3'b010;
  localparam logic [2:0] MASK_OVL   = 3'b100;
  localparam logic [2:0] MASK_ALL   = 3'b111;

  localparam logic [2:0] MASK_PLAN [9] = '{
    MASK_CHUNK, MASK_ALL, MASK_NONE, MASK_SIG | MASK_OVL, MASK_SIG,
    MASK_OVL, MASK_CHUNK | MASK_OVL, MASK_SIG | MASK_CHUNK, MASK_ALL
  };
  localparam int HOLD_PHASE = 1;

  typedef enum logic [2:0] {W_SIG, W_LEN, W_TYPE, W_DATA, W_CRC, W_DONE} walk_phase_e;
  typedef enum logic [1:0] {PACE_FULL, PACE_SLOW, PACE_SPARSE, PACE_LIGHT} pace_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [OB-1:0] offset;
    logic [OB-1:0] size;
    logic [31:0]   tag;
    logic          good;
    logic          endc;
  } region_rec_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_data = 3'd0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_data = 8'd0;
  logic       drv_fin = 1'b0;
  logic       mon_ready = 1'b0;

  pcsw_in_if in_ch ();
  pcsw_out_if #(.OFFSET_BITS(OB)) out_ch ();

  assign in_ch.valid      = drv_valid;
  assign in_ch.data_byte  = drv_data;
  assign in_ch.final_byte = drv_fin;
  assign out_ch.ready     = mon_ready;

  png_chunk_stream_walker_core #(.OFFSET_BITS(OB)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  in_beat_t    feed_q [$];
  region_rec_t expect_q [$];
  int          errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  pace_e       tx_pace = PACE_FULL;
  pace_e       rx_pace = PACE_FULL;

  // walker state as the block should hold it
  walk_phase_e   ph;
  logic [31:0]   fcnt;
  logic [31:0]   clen;
  logic [31:0]   ctype;
  logic [OB-1:0] fofs;
  logic [OB-1:0] cstart;
  logic          sig_ok;
  logic [2:0]    mask_model = MASK_ALL;

  function automatic logic [7:0] magic_at(input int i);
    return PNG_MAGIC[8*(7-i) +: 8];
  endfunction

  function automatic logic [OB-1:0] bump(input logic [OB-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic int unsigned draw_wait(input pace_e pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_SLOW:   return $urandom_range(0, 18);
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
      default:     return $urandom_range(0, 2);
    endcase
  endfunction

  task automatic clear_walk();
    ph = W_SIG;
    fcnt = '0;
    clen = '0;
    ctype = '0;
    fofs = '0;
    cstart = OB'(pcsw_pkg::SIG_LEN);
    sig_ok = 1'b1;
  endtask

  initial clear_walk();

  task automatic walk_byte(input logic [7:0] b, input logic last);
    region_rec_t   rec;
    logic          emitted;
    logic          is_end;
    logic [OB-1:0] total;
    rec = '0;
    emitted = 1'b0;
    case (ph)
      W_SIG: begin
        if (b != magic_at(int'(fcnt[2:0]))) sig_ok = 1'b0;
        fcnt = fcnt + 1;
        if (fcnt >= pcsw_pkg::SIG_LEN) begin
          fcnt = '0;
          ph = W_LEN;
          if ((mask_model & MASK_SIG) != 0) begin
            rec.kind = pcsw_pkg::KIND_SIG;
            rec.size = OB'(pcsw_pkg::SIG_LEN);
            rec.good = sig_ok;
            emitted = 1'b1;
          end
        end
      end
      W_LEN: begin
        clen = {clen[23:0], b};
        fcnt = fcnt + 1;
        if (fcnt >= 4) begin
          fcnt = '0;
          ph = W_TYPE;
        end
      end
      W_TYPE: begin
        ctype = {ctype[23:0], b};
        fcnt = fcnt + 1;
        if (fcnt >= 4) begin
          fcnt = '0;
          ph = (clen == 0) ? W_CRC : W_DATA;
        end
      end
      W_DATA: begin
        fcnt = fcnt + 1;
        if (fcnt >= clen) begin
          fcnt = '0;
          ph = W_CRC;
        end
      end
      W_CRC: begin
        fcnt = fcnt + 1;
        if (fcnt >= 4) begin
          is_end = (ctype == pcsw_pkg::TAG_IEND);
          if ((mask_model & MASK_CHUNK) != 0) begin
            rec.kind = pcsw_pkg::KIND_CHUNK;
            rec.offset = cstart;
            rec.size = OB'(clen) + OB'(pcsw_pkg::CHUNK_OVERHEAD);
            rec.tag = ctype;
            rec.endc = is_end;
            emitted = 1'b1;
          end
          cstart = bump(fofs);
          fcnt = '0;
          clen = '0;
          ctype = '0;
          ph = is_end ? W_DONE : W_LEN;
        end
      end
      default: ;
    endcase
    total = bump(fofs);
    fofs = total;
    if (last) begin
      // a file cut inside the signature still reports it, as a bad one
      if (ph == W_SIG) begin
        if ((mask_model & MASK_SIG) != 0) begin
          rec.kind = pcsw_pkg::KIND_SIG;
          rec.size = OB'(pcsw_pkg::SIG_LEN);
          rec.good = 1'b0;
          emitted = 1'b1;
        end
      end else if (!emitted && (mask_model & MASK_OVL) != 0 && cstart < total) begin
        rec.kind = pcsw_pkg::KIND_OVL;
        rec.offset = cstart;
        rec.size = total - cstart;
        emitted = 1'b1;
      end
      clear_walk();
    end
    if (emitted) expect_q.push_back(rec);
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_record(input region_rec_t got);
    region_rec_t want;
    if (expect_q.size() == 0) begin
      $error("record with nothing expected: kind %0d offset %0d size %0d",
             got.kind, got.offset, got.size);
      errors++;
      return;
    end
    want = expect_q.pop_front();
    note_mismatch("record_kind", 64'(want.kind), 64'(got.kind));
    note_mismatch("record_offset", 64'(want.offset), 64'(got.offset));
    note_mismatch("record_size", 64'(want.size), 64'(got.size));
    note_mismatch("chunk_tag", 64'(want.tag), 64'(got.tag));
    note_mismatch("signature_good", 64'(want.good), 64'(got.good));
    note_mismatch("end_chunk", 64'(want.endc), 64'(got.endc));
  endtask

  // file builders
  task automatic put_byte(input logic [7:0] b);
    in_beat_t it;
    it.data = b;
    it.fin = 1'b0;
    feed_q.push_back(it);
  endtask

  task automatic mark_final();
    in_beat_t it;
    it = feed_q.pop_back();
    it.fin = 1'b1;
    feed_q.push_back(it);
  endtask

  task automatic put_signature(input logic corrupt);
    int bad;
    bad = corrupt ? int'($urandom_range(0, 7)) : 8;
    for (int i = 0; i < 8; i++)
      put_byte(i == bad ? magic_at(i) ^ 8'($urandom_range(1, 255)) : magic_at(i));
  endtask

  task automatic put_chunk(input logic [31:0] len, input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8]);
    for (int i = 3; i >= 0; i--) put_byte(tag[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++) put_byte(8'($urandom()));
    repeat (4) put_byte(8'($urandom()));
  endtask

  function automatic logic [31:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 16);
    if (r < 96) return $urandom_range(17, 64);
    return $urandom_range(256, 300);
  endfunction

  task automatic gen_file();
    int unsigned pick;
    int unsigned cut;
    int unsigned n;
    logic        use_magic;
    logic [31:0] len;
    logic [31:0] tag;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      put_signature($urandom_range(0, 9) == 0);
      repeat ($urandom_range(0, 4)) put_chunk(pick_len(), $urandom());
      if ($urandom_range(0, 2) != 0)
        put_chunk(($urandom_range(0, 7) == 0) ? pick_len() : 32'd0, pcsw_pkg::TAG_IEND);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom()));
    end else if (pick < 75) begin
      put_signature($urandom_range(0, 5) == 0);
      repeat ($urandom_range(0, 2)) put_chunk(pick_len(), $urandom());
      // cut the next chunk inside its length, type or first data bytes
      len = $urandom();
      tag = $urandom();
      cut = $urandom_range(1, 14);
      for (int i = 0; i < int'(cut); i++) begin
        if (i < 4) put_byte(len[8*(3-i) +: 8]);
        else if (i < 8) put_byte(tag[8*(7-i) +: 8]);
        else put_byte(8'($urandom()));
      end
    end else if (pick < 88) begin
      n = $urandom_range(1, 8);
      use_magic = 1'($urandom_range(0, 1));
      for (int i = 0; i < int'(n); i++) put_byte(use_magic ? magic_at(i) : 8'($urandom()));
    end else begin
      repeat ($urandom_range(9, 40)) put_byte(8'($urandom()));
    end
    mark_final();
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || drv_valid || expect_q.size() != 0) @(negedge clk);
    // let trailing beats that make no record clear the pipeline
    repeat (10) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_p
    in_beat_t it;
    if (rst) begin
      drv_valid <= 1'b0;
      gap_left <= 0;
    end else if (!drv_valid || in_ch.ready) begin
      if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (feed_q.size() != 0) begin
        it = feed_q.pop_front();
        drv_valid <= 1'b1;
        drv_data <= it.data;
        drv_fin <= it.fin;
        gap_left <= draw_wait(tx_pace);
        if (it.fin) tx_pace <= pace_e'($urandom_range(0, 3));
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : predict_p
    if (!rst && in_ch.valid && in_ch.ready) walk_byte(in_ch.data_byte, in_ch.final_byte);
  end

  always @(posedge clk) begin : hold_p
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : watch_p
    int unsigned s;
    region_rec_t got;
    if (rst) begin
      mon_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      s = stall_left;
      if (out_ch.valid && mon_ready) begin
        got.kind = out_ch.record_kind;
        got.offset = out_ch.record_offset;
        got.size = out_ch.record_size;
        got.tag = out_ch.chunk_tag;
        got.good = out_ch.signature_good;
        got.endc = out_ch.end_chunk;
        check_record(got);
        s = draw_wait(rx_pace);
        if ($urandom_range(0, 15) == 0) rx_pace <= pace_e'($urandom_range(0, 3));
      end else if (s != 0) begin
        s = s - 1;
      end
      stall_left <= s;
      mon_ready <= (s == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin : watchdog_p
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim_p
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // minimal file with trailing byte after IEND, then a two-byte file
    put_signature(1'b0);
    put_chunk(32'd0, pcsw_pkg::TAG_IEND);
    put_byte(8'hFF);
    mark_final();
    put_byte(8'h00);
    put_byte(8'h89);
    mark_final();
    drain();

    foreach (MASK_PLAN[p]) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_data <= MASK_PLAN[p];
      mask_model = MASK_PLAN[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      if (p == HOLD_PHASE) begin
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
        // one-byte files first, so records pile up behind the held output
        repeat (6) begin
          put_byte(8'h89);
          mark_final();
        end
      end
      while (feed_q.size() < PHASE_BYTES) gen_file();
      drain();
    end

    repeat (20) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
